[hdl/stg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo tone, gain and PCM formatter: shared definitions
// Widths, register map, control structs and the sine table generator used by
// the datapath modules of the block.
// ----------------------------------------------------------------------------
package stg_pkg;

	// Sample and arithmetic widths.
	localparam int SAMPLE_BITS         = 16;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int PHASE_BITS          = 32;
	localparam int GAIN_BITS           = 16;
	localparam int FRAC_BITS           = 15;
	localparam int ROUND_HALF          = 1 << (FRAC_BITS - 1);

	// Sine value times tone gain, and the rounded tone that results.
	localparam int TONE_PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int CH_BITS        = TONE_PROD_BITS - FRAC_BITS;
	// Channel value times output gain, and the rounded value before saturation.
	localparam int PROD_BITS      = CH_BITS + GAIN_BITS + 1;
	localparam int SCALED_BITS    = PROD_BITS - FRAC_BITS;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX_CODE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN_CODE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Register map: register i sits at byte address 4*i.
	localparam int REG_IDX_BITS  = 3;
	localparam int REG_ADDR_BITS = REG_IDX_BITS + 2;
	localparam int APB_DATA_BITS = 32;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_TONE_ENABLE,
		REG_PHASE_STEP,
		REG_TONE_GAIN,
		REG_TONE_MASK,
		REG_GAIN_LEFT,
		REG_GAIN_RIGHT,
		REG_CHANNEL_COUNT,
		REG_SAMPLE_FORMAT
	} reg_idx_t;

	// Output word format selection.
	typedef struct packed {
		logic offset_bin;
		logic big_endian;
	} fmt_cfg_t;

	// Control handed from the datapath to the output merge stage.
	typedef struct packed {
		logic start;
		logic two_ch;
	} merge_ctl_t;

	// Pi/2 in Q30.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Sine of (q / 2^qbits) * pi/2 scaled to full scale, by a Q30 Taylor
	// series up to the x^11 term, rounded half up and clamped. Evaluated at
	// elaboration only, to build the quarter-wave table.
	function automatic logic [SAMPLE_BITS-1:0] quarter_sine(int unsigned q,
		int unsigned qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		longint unsigned t;
		x    = ({32'd0, q} * HALF_PI_Q30) >> qbits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int k = 1; k <= 5; k++) begin
			t = (term * x2) >> 30;
			case (k)
				1:       term = t / 6;
				2:       term = t / 20;
				3:       term = t / 42;
				4:       term = t / 72;
				default: term = t / 110;
			endcase
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

[hdl/stg_sine_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine table ROM
// Full-wave signed sine lookup built from a quarter-wave constant table, with
// a registered read.
// ----------------------------------------------------------------------------
module stg_sine_rom #(
	parameter int ADDR_BITS = stg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [ADDR_BITS-1:0]                 addr,
	output logic signed [stg_pkg::SAMPLE_BITS-1:0] data
);
	import stg_pkg::*;

	localparam int QUARTER_BITS = ADDR_BITS - 2;
	localparam int QUARTER      = 1 << QUARTER_BITS;
	localparam logic [QUARTER_BITS:0] QUARTER_V = (QUARTER_BITS + 1)'(QUARTER);

	typedef logic [SAMPLE_BITS-1:0] qtab_t [QUARTER+1];

	function automatic qtab_t build_qtab();
		qtab_t tab;
		for (int i = 0; i <= QUARTER; i++) begin
			tab[i] = quarter_sine(i, QUARTER_BITS);
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	logic [1:0]                    quad;
	logic [QUARTER_BITS-1:0]       offs;
	logic [QUARTER_BITS:0]         qidx;
	logic signed [SAMPLE_BITS-1:0] mag;

	// Mirror the index in odd quadrants; the sign comes from the upper half.
	assign quad = addr[ADDR_BITS-1 -: 2];
	assign offs = addr[QUARTER_BITS-1:0];
	assign qidx = quad[0] ? (QUARTER_V - {1'b0, offs}) : {1'b0, offs};
	assign mag  = signed'(QTAB[qidx]);

	// Registered read.
	always_ff @(posedge clk) begin
		if (en) begin
			data <= quad[1] ? -mag : mag;
		end
	end

endmodule

[hdl/stg_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel lane
// Scales one channel by its output gain, rounds, saturates to the sample
// range and formats the result as a PCM word.
// ----------------------------------------------------------------------------
module stg_lane (
	input  logic                                  clk,
	input  logic signed [stg_pkg::CH_BITS-1:0]    ch,
	input  logic [stg_pkg::GAIN_BITS-1:0]         gain,
	input  stg_pkg::fmt_cfg_t                     fmt,
	output logic [stg_pkg::SAMPLE_BITS-1:0]       word
);
	import stg_pkg::*;

	logic signed [PROD_BITS-1:0]   prod_s3;
	logic signed [PROD_BITS-1:0]   rounded;
	logic [SCALED_BITS-1:0]        scaled;
	logic [SCALED_BITS-SAMPLE_BITS:0] top_bits;
	logic [SAMPLE_BITS-1:0]        sat;
	logic [SAMPLE_BITS-1:0]        coded;

	// Gain multiply, registered before rounding.
	always_ff @(posedge clk) begin
		prod_s3 <= ch * $signed({1'b0, gain});
	end

	// Round half up and drop the fraction bits.
	assign rounded = prod_s3 + PROD_BITS'(ROUND_HALF);
	assign scaled  = rounded[PROD_BITS-1:FRAC_BITS];

	// Saturate when the sample sign bit and the bits above it are not all equal.
	assign top_bits = scaled[SCALED_BITS-1:SAMPLE_BITS-1];
	always_comb begin
		if ((&top_bits) || !(|top_bits)) begin
			sat = scaled[SAMPLE_BITS-1:0];
		end else if (scaled[SCALED_BITS-1]) begin
			sat = SAMPLE_MIN_CODE;
		end else begin
			sat = SAMPLE_MAX_CODE;
		end
	end

	// Offset binary flips the sign bit; big endian swaps the bytes.
	assign coded = {sat[SAMPLE_BITS-1] ^ fmt.offset_bin, sat[SAMPLE_BITS-2:0]};
	assign word  = fmt.big_endian ? {coded[7:0], coded[15:8]} : coded;

endmodule

[hdl/stg_out_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output merge stage
// Takes the words of both lanes for one frame and sends them out as beats,
// left first, marking the final word of the frame.
// ----------------------------------------------------------------------------
module stg_out_merge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  stg_pkg::merge_ctl_t             ctl,
	input  logic [stg_pkg::SAMPLE_BITS-1:0] word_left,
	input  logic [stg_pkg::SAMPLE_BITS-1:0] word_right,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [stg_pkg::SAMPLE_BITS-1:0] pcm_word,
	output logic                            channel_index,
	output logic                            last_of_frame
);
	import stg_pkg::*;

	logic                   valid_q;
	logic                   pend_q;
	logic [SAMPLE_BITS-1:0] word_q;
	logic [SAMPLE_BITS-1:0] right_q;
	logic                   idx_q;
	logic                   last_q;
	logic                   beat;

	assign beat = valid_q && out_ready;

	// Output valid and the pending right word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (ctl.start) begin
			valid_q <= 1'b1;
			pend_q  <= ctl.two_ch;
		end else if (beat) begin
			valid_q <= pend_q;
			pend_q  <= 1'b0;
		end
	end

	// Payload: the left word goes out first, the right word is held behind it.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			word_q  <= word_left;
			right_q <= word_right;
			idx_q   <= 1'b0;
			last_q  <= !ctl.two_ch;
		end else if (beat && pend_q) begin
			word_q <= right_q;
			idx_q  <= 1'b1;
			last_q <= 1'b1;
		end
	end

	assign out_valid     = valid_q;
	assign pcm_word      = word_q;
	assign channel_index = idx_q;
	assign last_of_frame = last_q;

endmodule

[hdl/stereo_tone_gain_pcm_formatter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo tone, gain and PCM formatter
// Frame-rate sine tone or upstream passthrough, per-channel gain, saturation
// and 16-bit PCM formatting, with an APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes one beat per audio frame,
// carrying ext_left and ext_right. With the tone enabled, the phase
// accumulator selects a sine table entry and advances by phase_step; the
// upstream samples are then ignored. The output channel (out_valid/out_ready)
// sends one beat per channel, left first, with last_of_frame on the final
// word; in single channel mode only the left word goes out.
// The first word passes through the sine ROM read, the tone multiply, the
// lane gain multiply and the output merge register. The block holds one
// frame at a time: in_ready drops after the input beat and returns the cycle
// after the final word is taken. A stalled receiver holds the current word
// and input stays blocked until it is taken.
// Reset loads the register defaults and clears the phase and all valid state.
// The user must see that registers are written only while no frame is in
// flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module stereo_tone_gain_pcm_formatter #(
	parameter int SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [stg_pkg::REG_ADDR_BITS-1:0]     paddr,
	input  logic [stg_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [stg_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                  pready,
	// Input frames
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [stg_pkg::SAMPLE_BITS-1:0] ext_left,
	input  logic signed [stg_pkg::SAMPLE_BITS-1:0] ext_right,
	// Output words
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [stg_pkg::SAMPLE_BITS-1:0]       pcm_word,
	output logic                                  channel_index,
	output logic                                  last_of_frame
);
	import stg_pkg::*;

	// Configuration registers.
	logic                  tone_enable_q;
	logic [PHASE_BITS-1:0] phase_step_q;
	logic [GAIN_BITS-1:0]  tone_gain_q;
	logic [1:0]            tone_mask_q;
	logic [GAIN_BITS-1:0]  gain_left_q;
	logic [GAIN_BITS-1:0]  gain_right_q;
	logic [1:0]            chan_count_q;
	logic [1:0]            sample_fmt_q;
	logic                  cfg_wr;
	reg_idx_t              reg_idx;

	// Frame control and datapath.
	logic                         busy_q;
	logic                         in_acc;
	logic                         last_acc;
	logic [PHASE_BITS-1:0]        tone_phase_q;
	logic signed [SAMPLE_BITS-1:0] sine_s1;
	logic signed [SAMPLE_BITS-1:0] ext_l_s1;
	logic signed [SAMPLE_BITS-1:0] ext_r_s1;
	logic                         tone_s1;
	logic                         v_s1;
	logic signed [TONE_PROD_BITS-1:0] tone_prod_s2;
	logic signed [SAMPLE_BITS-1:0] ext_l_s2;
	logic signed [SAMPLE_BITS-1:0] ext_r_s2;
	logic                         tone_s2;
	logic                         v_s2;
	logic                         v_s3;
	logic signed [TONE_PROD_BITS-1:0] tone_sum;
	logic signed [CH_BITS-1:0]    tone_val;
	logic signed [CH_BITS-1:0]    ch_left;
	logic signed [CH_BITS-1:0]    ch_right;
	logic [SAMPLE_BITS-1:0]       word_left;
	logic [SAMPLE_BITS-1:0]       word_right;
	fmt_cfg_t                     fmt;
	merge_ctl_t                   merge_ctl;

	// Register writes complete in the access cycle.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[REG_ADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_enable_q <= 1'b0;
			phase_step_q  <= 32'd42852281;
			tone_gain_q   <= 16'd16384;
			tone_mask_q   <= 2'd3;
			gain_left_q   <= 16'd32768;
			gain_right_q  <= 16'd32768;
			chan_count_q  <= 2'd2;
			sample_fmt_q  <= 2'd0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TONE_ENABLE:   tone_enable_q <= pwdata[0];
				REG_PHASE_STEP:    phase_step_q  <= pwdata[PHASE_BITS-1:0];
				REG_TONE_GAIN:     tone_gain_q   <= pwdata[GAIN_BITS-1:0];
				REG_TONE_MASK:     tone_mask_q   <= pwdata[1:0];
				REG_GAIN_LEFT:     gain_left_q   <= pwdata[GAIN_BITS-1:0];
				REG_GAIN_RIGHT:    gain_right_q  <= pwdata[GAIN_BITS-1:0];
				REG_CHANNEL_COUNT: chan_count_q  <= pwdata[1:0];
				REG_SAMPLE_FORMAT: sample_fmt_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (reg_idx)
			REG_TONE_ENABLE:   prdata = {31'd0, tone_enable_q};
			REG_PHASE_STEP:    prdata = phase_step_q;
			REG_TONE_GAIN:     prdata = {16'd0, tone_gain_q};
			REG_TONE_MASK:     prdata = {30'd0, tone_mask_q};
			REG_GAIN_LEFT:     prdata = {16'd0, gain_left_q};
			REG_GAIN_RIGHT:    prdata = {16'd0, gain_right_q};
			REG_CHANNEL_COUNT: prdata = {30'd0, chan_count_q};
			REG_SAMPLE_FORMAT: prdata = {30'd0, sample_fmt_q};
			default:           prdata = '0;
		endcase
	end

	// One frame in flight: busy from the input beat to the final output beat.
	assign in_ready = !busy_q;
	assign in_acc   = in_valid && in_ready;
	assign last_acc = out_valid && out_ready && last_of_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
		end else if (last_acc) begin
			busy_q <= 1'b0;
		end
	end

	// Phase accumulator advances only on tone frames.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_phase_q <= '0;
		end else if (in_acc && tone_enable_q) begin
			tone_phase_q <= tone_phase_q + phase_step_q;
		end
	end

	stg_sine_rom #(
		.ADDR_BITS(SINE_TABLE_BITS)
	) u_sine_rom (
		.clk (clk),
		.en  (in_acc),
		.addr(tone_phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS]),
		.data(sine_s1)
	);

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 captures the frame; stage 2 scales the sine by the tone gain.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ext_l_s1 <= ext_left;
			ext_r_s1 <= ext_right;
			tone_s1  <= tone_enable_q;
		end
		if (v_s1) begin
			tone_prod_s2 <= sine_s1 * $signed({1'b0, tone_gain_q});
			ext_l_s2     <= ext_l_s1;
			ext_r_s2     <= ext_r_s1;
			tone_s2      <= tone_s1;
		end
	end

	// Rounded tone, gated per channel, or the upstream samples.
	assign tone_sum = tone_prod_s2 + TONE_PROD_BITS'(ROUND_HALF);
	assign tone_val = tone_sum[TONE_PROD_BITS-1:FRAC_BITS];

	always_comb begin
		if (tone_s2) begin
			ch_left  = tone_mask_q[0] ? tone_val : '0;
			ch_right = tone_mask_q[1] ? tone_val : '0;
		end else begin
			ch_left  = CH_BITS'(ext_l_s2);
			ch_right = CH_BITS'(ext_r_s2);
		end
	end

	assign fmt.offset_bin = sample_fmt_q[0];
	assign fmt.big_endian = sample_fmt_q[1];

	stg_lane u_lane_left (
		.clk (clk),
		.ch  (ch_left),
		.gain(gain_left_q),
		.fmt (fmt),
		.word(word_left)
	);

	stg_lane u_lane_right (
		.clk (clk),
		.ch  (ch_right),
		.gain(gain_right_q),
		.fmt (fmt),
		.word(word_right)
	);

	// A channel count of two or three emits both channels.
	assign merge_ctl.start  = v_s3;
	assign merge_ctl.two_ch = chan_count_q[1];

	stg_out_merge u_out_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (merge_ctl),
		.word_left    (word_left),
		.word_right   (word_right),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.pcm_word     (pcm_word),
		.channel_index(channel_index),
		.last_of_frame(last_of_frame)
	);

`ifndef SYNTHESIS
	// No second frame is taken while one is in flight.
	a_single_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input beat accepted while a frame is in flight");

	// Passthrough frames leave the phase untouched.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !tone_enable_q) |=> $stable(tone_phase_q))
		else $error("phase moved on a passthrough frame");

	// Output words only appear for a frame in flight.
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy_q)
		else $error("output word without a frame in flight");

	// The right word always closes the frame.
	a_right_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && channel_index) |-> last_of_frame)
		else $error("right channel word not marked last");

	// Taking the final word frees the input.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		last_acc |=> in_ready)
		else $error("input not released after the final word");
`endif

endmodule

[verif/stereo_tone_gain_pcm_formatter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo tone, gain and PCM formatter testbench
// Drives audio frame beats and register writes into the block, predicts every
// output word from a local model of the tone generator, gain stages and word
// formatting, and checks each output beat in order. Both handshakes see
// random gaps and stalls, and the register settings change between phases.
// ----------------------------------------------------------------------------

// One expected or observed output beat.
typedef struct packed {
	logic [15:0] word;
	logic        chan;
	logic        last;
} pcm_beat_t;

// Tracks register state and tone phase, and holds the words still owed.
class pcm_tracker;
	logic        tone_on;
	logic [31:0] step;
	logic [15:0] tone_gain;
	logic [1:0]  tone_mask;
	logic [15:0] gain_l;
	logic [15:0] gain_r;
	logic [1:0]  chan_count;
	logic [1:0]  sample_fmt;
	logic [31:0] phase;
	logic signed [15:0] sine_rom [0:(1 << stg_pkg::SINE_TABLE_BITS_DEF)-1];
	pcm_beat_t   owed_words [$];
	int          errors;

	function new();
		int unsigned quarter;
		int unsigned quad;
		int unsigned r;
		longint unsigned m;
		logic signed [15:0] e;
		tone_on    = 1'b0;
		step       = 32'd42852281;
		tone_gain  = 16'd16384;
		tone_mask  = 2'd3;
		gain_l     = 16'd32768;
		gain_r     = 16'd32768;
		chan_count = 2'd2;
		sample_fmt = 2'd0;
		phase      = '0;
		errors     = 0;
		// Build the full table from one quarter wave, mirrored and negated.
		quarter = (1 << stg_pkg::SINE_TABLE_BITS_DEF) / 4;
		for (int i = 0; i < (1 << stg_pkg::SINE_TABLE_BITS_DEF); i++) begin
			quad = i / quarter;
			r    = i % quarter;
			m    = (quad & 1) ? sine_quarter(quarter - r, quarter) : sine_quarter(r, quarter);
			e    = m[15:0];
			if (quad & 2) begin
				e = -e;
			end
			sine_rom[i] = e;
		end
	endfunction

	// Quarter-wave sine in Q30 by a Taylor series, scaled to full scale.
	function longint unsigned sine_quarter(int unsigned q, int unsigned quarter);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		x    = q;
		x    = (x * stg_pkg::HALF_PI_Q30) / quarter;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int k = 1; k <= 5; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v;
	endfunction

	// Q1.15 product rounded half up, which is a floor after adding one half.
	function longint q15_round(longint a, logic [15:0] g);
		longint p;
		p = a * longint'(g) + 16384;
		return p >>> 15;
	endfunction

	// Saturate to 16 bits, then apply offset binary and byte order.
	function logic [15:0] pack_word(longint v);
		logic [15:0] w;
		if (v > 32767) begin
			v = 32767;
		end else if (v < -32768) begin
			v = -32768;
		end
		w = v[15:0];
		if (sample_fmt[0]) begin
			w[15] = ~w[15];
		end
		if (sample_fmt[1]) begin
			w = {w[7:0], w[15:8]};
		end
		return w;
	endfunction

	function void set_reg(stg_pkg::reg_idx_t idx, logic [31:0] val);
		case (idx)
			stg_pkg::REG_TONE_ENABLE:   tone_on    = val[0];
			stg_pkg::REG_PHASE_STEP:    step       = val;
			stg_pkg::REG_TONE_GAIN:     tone_gain  = val[15:0];
			stg_pkg::REG_TONE_MASK:     tone_mask  = val[1:0];
			stg_pkg::REG_GAIN_LEFT:     gain_l     = val[15:0];
			stg_pkg::REG_GAIN_RIGHT:    gain_r     = val[15:0];
			stg_pkg::REG_CHANNEL_COUNT: chan_count = val[1:0];
			default:                    sample_fmt = val[1:0];
		endcase
	endfunction

	// Work out the words that one accepted frame beat produces.
	function void take_frame(logic signed [15:0] l, logic signed [15:0] r);
		longint lane [2];
		longint tone;
		longint v;
		int n;
		pcm_beat_t b;
		n = (chan_count >= 2) ? 2 : 1;
		if (tone_on) begin
			tone    = q15_round(longint'(sine_rom[phase >> (32 - stg_pkg::SINE_TABLE_BITS_DEF)]),
				tone_gain);
			lane[0] = tone_mask[0] ? tone : 0;
			lane[1] = tone_mask[1] ? tone : 0;
			phase   = phase + step;
		end else begin
			lane[0] = longint'(l);
			lane[1] = longint'(r);
		end
		for (int c = 0; c < n; c++) begin
			v      = q15_round(lane[c], (c == 0) ? gain_l : gain_r);
			b.word = pack_word(v);
			b.chan = (c == 1);
			b.last = (c == n - 1);
			owed_words.push_back(b);
		end
	endfunction

	// Compare one output beat against the oldest owed word.
	function void check_word(logic [15:0] w, logic ch, logic last);
		pcm_beat_t b;
		if (owed_words.size() == 0) begin
			$display("%0t: unexpected word, actual %h channel %0b last %0b", $time, w, ch, last);
			errors++;
			return;
		end
		b = owed_words.pop_front();
		if (w !== b.word) begin
			$display("%0t: pcm_word mismatch, expected %h, actual %h", $time, b.word, w);
			errors++;
		end
		if (ch !== b.chan) begin
			$display("%0t: channel_index mismatch, expected %0b, actual %0b", $time, b.chan, ch);
			errors++;
		end
		if (last !== b.last) begin
			$display("%0t: last_of_frame mismatch, expected %0b, actual %0b", $time, b.last, last);
			errors++;
		end
	endfunction

	function int pending();
		return owed_words.size();
	endfunction
endclass

module stereo_tone_gain_pcm_formatter_tb;
	import stg_pkg::*;

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int RANDOM_PHASES    = 16;
	localparam int FRAMES_PER_PHASE = 122;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [REG_ADDR_BITS-1:0]  paddr;
	logic [APB_DATA_BITS-1:0]  pwdata;
	logic [APB_DATA_BITS-1:0]  prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [SAMPLE_BITS-1:0] ext_left;
	logic signed [SAMPLE_BITS-1:0] ext_right;
	logic                      out_valid;
	logic                      out_ready;
	logic [SAMPLE_BITS-1:0]    pcm_word;
	logic                      channel_index;
	logic                      last_of_frame;

	pcm_tracker tracker;
	int         stall_cycles;

	stereo_tone_gain_pcm_formatter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.ext_left      (ext_left),
		.ext_right     (ext_right),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pcm_word      (pcm_word),
		.channel_index (channel_index),
		.last_of_frame (last_of_frame)
	);

	always #6 clk = ~clk;

	// Output beats are checked as they are taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.check_word(pcm_word, channel_index, last_of_frame);
		end
	end

	// Abort when no beat or register access happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Receiver: bursts of steady readiness, light and heavy stalls, and rare long stalls.
	initial begin : receiver
		int burst;
		int mode;
		out_ready = 1'b0;
		forever begin
			burst = $urandom_range(1, 48);
			mode  = $urandom_range(0, 11);
			repeat (burst) begin
				@(posedge clk);
				if (mode < 5) begin
					out_ready <= 1'b1;
				end else if (mode < 10) begin
					out_ready <= ($urandom_range(0, 3) != 0);
				end else if (mode == 10) begin
					out_ready <= ($urandom_range(0, 1) != 0);
				end else begin
					out_ready <= 1'b0;
				end
			end
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 7))
			0:       return 16'd0;
			1:       return 16'd32768;
			2:       return 16'hFFFF;
			3:       return 16'($urandom_range(32769, 65535));
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return 32'hFFFFFFFF;
			2:       return $urandom_range(1, 1 << 24);
			default: return $urandom();
		endcase
	endfunction

	// Mostly short gaps between frames, a few long ones.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Present one frame beat and hold it until it is accepted.
	task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r);
		ext_left  <= l;
		ext_right <= r;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!in_ready);
		tracker.take_frame(l, r);
	endtask

	task automatic send_frames(int n);
		repeat (n) send_frame(pick_sample(), pick_sample());
	endtask

	task automatic pause_frames(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every owed word has been taken.
	task automatic drain_words();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	// Setup and access cycles; psel stays up so writes can run back to back.
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_reg(idx, val);
	endtask

	task automatic apply_config(logic te, logic [31:0] stp, logic [15:0] tg, logic [1:0] msk,
		logic [15:0] gl, logic [15:0] gr, logic [1:0] cc, logic [1:0] fm);
		drain_words();
		write_reg(REG_TONE_ENABLE, {31'd0, te});
		write_reg(REG_PHASE_STEP, stp);
		write_reg(REG_TONE_GAIN, {16'd0, tg});
		write_reg(REG_TONE_MASK, {30'd0, msk});
		write_reg(REG_GAIN_LEFT, {16'd0, gl});
		write_reg(REG_GAIN_RIGHT, {16'd0, gr});
		write_reg(REG_CHANNEL_COUNT, {30'd0, cc});
		write_reg(REG_SAMPLE_FORMAT, {30'd0, fm});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin : stimulus
		logic steady;
		tracker   = new();
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		ext_left  = '0;
		ext_right = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: passthrough, full-scale extremes and sign edges.
		send_frame(16'sh7FFF, 16'sh8000);
		send_frame(16'sh8000, 16'sh7FFF);
		send_frame(16'sh0000, 16'shFFFF);
		send_frame(16'sh0001, 16'sh5A3C);

		// Gains above unity saturate; offset binary, big endian.
		apply_config(1'b0, 32'd42852281, 16'd16384, 2'd3, 16'hFFFF, 16'd40000, 2'd2, 2'd3);
		send_frame(16'sh7FFF, 16'sh8000);
		send_frame(16'sh4E20, 16'shB1E0);
		send_frame(16'shFFFF, 16'sh0001);

		// Channel count zero acts as mono, three as stereo, one as mono.
		apply_config(1'b0, 32'd42852281, 16'd16384, 2'd3, 16'd32768, 16'd32768, 2'd0, 2'd1);
		send_frame(16'sh1234, 16'shABCD);
		send_frame(16'sh8000, 16'sh7FFF);
		apply_config(1'b0, 32'd42852281, 16'd16384, 2'd3, 16'd32768, 16'd32768, 2'd3, 2'd2);
		send_frame(16'sh7FFF, 16'sh8000);
		apply_config(1'b0, 32'd42852281, 16'd16384, 2'd3, 16'd16384, 16'd0, 2'd1, 2'd0);
		send_frame(16'shC000, 16'sh4000);

		// Tone at a quarter turn per frame visits zero, peaks and troughs.
		apply_config(1'b1, 32'h40000000, 16'd32768, 2'd3, 16'd32768, 16'd32768, 2'd2, 2'd0);
		send_frames(5);
		apply_config(1'b1, 32'h40000000, 16'd32768, 2'd1, 16'd32768, 16'd32768, 2'd2, 2'd0);
		send_frames(2);
		apply_config(1'b1, 32'h40000000, 16'd32768, 2'd2, 16'd32768, 16'd32768, 2'd2, 2'd0);
		send_frames(1);
		apply_config(1'b1, 32'h40000000, 16'd32768, 2'd0, 16'd32768, 16'd32768, 2'd2, 2'd1);
		send_frames(1);

		// Tone off holds the phase across the passthrough frame.
		apply_config(1'b0, 32'h40000000, 16'd32768, 2'd3, 16'd32768, 16'd32768, 2'd2, 2'd0);
		send_frames(1);

		// Largest step and tone gain, then a silent tone.
		apply_config(1'b1, 32'hFFFFFFFF, 16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF, 2'd2, 2'd2);
		send_frames(2);
		apply_config(1'b1, 32'hFFFFFFFF, 16'd0, 2'd3, 16'hFFFF, 16'hFFFF, 2'd2, 2'd0);
		send_frames(1);

		// Random phases: all maximum, all minimum, then random settings.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				apply_config(1'b1, 32'hFFFFFFFF, 16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF, 2'd3, 2'd3);
			end else if (p == 1) begin
				apply_config(1'b0, 32'd0, 16'd0, 2'd0, 16'd0, 16'd0, 2'd0, 2'd0);
			end else begin
				apply_config(1'($urandom_range(0, 1)), pick_step(), pick_gain(),
					2'($urandom_range(0, 3)), pick_gain(), pick_gain(),
					2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			end
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
				send_frame(pick_sample(), pick_sample());
				if (!steady) begin
					pause_frames(pick_gap());
				end
				if ($urandom_range(0, 199) == 0) begin
					drain_words();
				end
			end
		end

		// Let the last words out and give the block time to show any extras.
		drain_words();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
